FILE: rtl/core/cbsu_pkg.sv
package cbsu_pkg;

	localparam logic [1:0] STATUS_CHAR = 2'd0;
	localparam logic [1:0] STATUS_OK   = 2'd1;
	localparam logic [1:0] STATUS_ERR  = 2'd2;

	localparam logic REG_ACCEPT_FIRST  = 1'b0;
	localparam logic REG_ACCEPT_SECOND = 1'b1;

	localparam logic [15:0] ACCEPT_FIRST_RESET  = 16'd50;
	localparam logic [15:0] ACCEPT_SECOND_RESET = 16'd221;

	localparam logic [6:0] CR_SEPTET  = 7'h0D;
	localparam logic [7:0] POS_LIMIT  = 8'hFF;
	localparam logic [2:0] LAST_PHASE = 3'd6;
	localparam logic [2:0] SEPTET_BITS = 3'd7;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Bit 0: first character, bit 1: carried character, bit 2: end result.
	typedef struct packed {
		logic [2:0] valid_mask;
		logic [6:0] char0;
		logic [6:0] char1;
		logic [1:0] end_status;
	} job_t;

endpackage

FILE: rtl/core/cbsu_if.sv
interface cbsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;
	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface cbsu_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] character;
	logic [1:0] status;
	logic       last;
	modport source (output valid, output character, output status, output last, input ready);
	modport sink (input valid, input character, input status, input last, output ready);
endinterface

interface cbsu_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/cbsu_front.sv
module cbsu_front #(
	parameter int HEADER_BYTES   = 6,
	parameter int MAX_PAGE_BYTES = 255
) (
	input  logic           clk,
	input  logic           arst_n,
	cbsu_in_if.sink        page,
	cbsu_cfg_if.sink       cfg,
	output logic           push_valid,
	input  logic           push_ready,
	output cbsu_pkg::job_t push_data
);
	import cbsu_pkg::*;

	localparam logic [8:0] HDR_LIMIT  = 9'(HEADER_BYTES);
	localparam logic [8:0] PAGE_LIMIT = 9'(MAX_PAGE_BYTES);

	logic [15:0] accept_first_q, accept_second_q;
	logic [7:0]  pos_q, pos_n;
	logic [2:0]  off_q, off_n;
	logic [6:0]  carry_q, carry_n;
	logic [7:0]  idh_q, idh_n;
	logic        idok_q, idok_n;
	logic        stopped_q, stopped_n;

	logic        xfer;
	logic [2:0]  off;
	logic [14:0] shifted;
	logic [7:0]  carry_raw;
	logic [6:0]  sept;
	logic [8:0]  pos_next_wide;
	job_t        job;

	assign cfg.ready  = 1'b1;
	assign page.ready = push_ready;
	assign xfer       = page.valid && page.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_first_q  <= ACCEPT_FIRST_RESET;
			accept_second_q <= ACCEPT_SECOND_RESET;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == REG_ACCEPT_FIRST) begin
				accept_first_q <= cfg.data;
			end else begin
				accept_second_q <= cfg.data;
			end
		end
	end

	always_comb begin
		pos_n         = pos_q;
		off_n         = off_q;
		carry_n       = carry_q;
		idh_n         = idh_q;
		idok_n        = idok_q;
		stopped_n     = stopped_q;
		job           = '0;
		off           = (off_q > LAST_PHASE) ? 3'd0 : off_q;
		shifted       = 15'(page.data_byte) << off;
		carry_raw     = page.data_byte >> (SEPTET_BITS - off);
		sept          = shifted[6:0] | carry_q;
		pos_next_wide = {1'b0, pos_q} + 9'd1;

		if ({1'b0, pos_q} < PAGE_LIMIT) begin
			if (pos_q == 8'd2) begin
				idh_n = page.data_byte;
			end else if (pos_q == 8'd3) begin
				idok_n = ({idh_q, page.data_byte} == accept_first_q) ||
					({idh_q, page.data_byte} == accept_second_q);
			end
			if ({1'b0, pos_q} >= HDR_LIMIT && idok_q && !stopped_q) begin
				carry_n = carry_raw[6:0];
				if (sept == CR_SEPTET) begin
					stopped_n = 1'b1;
				end else begin
					job.valid_mask[0] = 1'b1;
					job.char0         = sept;
					if (off == LAST_PHASE) begin
						job.valid_mask[1] = 1'b1;
						job.char1         = carry_raw[6:0];
						carry_n           = '0;
						off_n             = '0;
					end else begin
						off_n = off + 3'd1;
					end
				end
			end
		end

		if (pos_q != POS_LIMIT) begin
			pos_n = pos_next_wide[7:0];
		end

		if (page.end_of_message) begin
			job.valid_mask[2] = 1'b1;
			job.end_status    = (idok_n && pos_next_wide >= HDR_LIMIT) ? STATUS_OK : STATUS_ERR;
			pos_n             = '0;
			off_n             = '0;
			carry_n           = '0;
			idh_n             = '0;
			idok_n            = 1'b0;
			stopped_n         = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			off_q     <= '0;
			carry_q   <= '0;
			idh_q     <= '0;
			idok_q    <= 1'b0;
			stopped_q <= 1'b0;
		end else if (xfer) begin
			pos_q     <= pos_n;
			off_q     <= off_n;
			carry_q   <= carry_n;
			idh_q     <= idh_n;
			idok_q    <= idok_n;
			stopped_q <= stopped_n;
		end
	end

	assign push_valid = xfer && (job.valid_mask != 3'b000);
	assign push_data  = job;

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		off_q != 3'd7)
		else $error("Septet phase left its range.");

	a_id_before_header: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < 8'd4 |-> !idok_q)
		else $error("Identifier marked as accepted before it was complete.");

endmodule

FILE: rtl/core/cbsu_queue.sv
module cbsu_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  cbsu_pkg::job_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output cbsu_pkg::job_t pop_data
);
	import cbsu_pkg::*;

	localparam logic [QCNT_W-1:0] FULL     = QCNT_W'(QUEUE_DEPTH);
	localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);

	job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign push_ready = count_q != FULL;
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_empty_job: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid |-> pop_data.valid_mask != 3'b000)
		else $error("Queue holds a job with no results.");

endmodule

FILE: rtl/core/cbsu_back.sv
module cbsu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  cbsu_pkg::job_t pop_data,
	cbsu_out_if.source     result
);
	import cbsu_pkg::*;

	job_t       job_q;
	logic [2:0] mask_q;
	logic [2:0] low_bit, rest;
	logic       xfer;

	assign low_bit = mask_q & (~mask_q + 3'd1);
	assign rest    = mask_q & ~low_bit;
	assign xfer    = result.valid && result.ready;

	assign result.valid = mask_q != 3'b000;
	assign result.last  = rest == 3'b000;
	assign pop_ready    = (mask_q == 3'b000) || (xfer && rest == 3'b000);

	always_comb begin
		if (mask_q[0]) begin
			result.character = job_q.char0;
			result.status    = STATUS_CHAR;
		end else if (mask_q[1]) begin
			result.character = job_q.char1;
			result.status    = STATUS_CHAR;
		end else begin
			result.character = '0;
			result.status    = job_q.end_status;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			job_q <= pop_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (pop_valid && pop_ready) begin
			mask_q <= pop_data.valid_mask;
		end else if (xfer) begin
			mask_q <= rest;
		end
	end

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.status != 2'd3)
		else $error("Result carries an undefined status.");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status != STATUS_CHAR |-> result.last)
		else $error("End result not marked as the final one of its byte.");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> $stable(mask_q))
		else $error("Pending results changed while the output was stalled.");

endmodule

FILE: rtl/core/cell_broadcast_septet_unpacker_top.sv
// Channel  Direction  Payload                          Transfer when
// page     sink       data_byte[7:0], end_of_message   page.valid && page.ready
// result   source     character[6:0], status[1:0], last result.valid && result.ready
// cfg      sink       index, data[15:0]                cfg.valid && cfg.ready
// A byte is classified in the cycle it is taken and its results leave one per cycle from the
// single output port of the back end while it is not stalled, so a byte yields zero to three
// results, one for an ordinary text byte; they pass through the queue and the job register.
// A two-entry job queue lets bytes keep arriving while results wait; the page input stalls
// only while it is full. The asynchronous reset clears the page state, the queue and the
// output; the identifiers return to 50 and 221. The configuration port is always ready.
module cell_broadcast_septet_unpacker_top #(
	parameter int HEADER_BYTES   = 6,
	parameter int MAX_PAGE_BYTES = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	cbsu_in_if.sink     page,
	cbsu_out_if.source  result,
	cbsu_cfg_if.sink    cfg
);
	import cbsu_pkg::*;

	logic push_valid, push_ready, pop_valid, pop_ready;
	job_t push_data, pop_data;

	cbsu_front #(
		.HEADER_BYTES  (HEADER_BYTES),
		.MAX_PAGE_BYTES(MAX_PAGE_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.page      (page),
		.cfg       (cfg),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	cbsu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	cbsu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.result   (result)
	);

endmodule

FILE: tb/cbsu_page_checker.sv
`timescale 1ns / 1ps

module cbsu_page_checker #(
	parameter int HEADER_BYTES   = 6,
	parameter int MAX_PAGE_BYTES = 255
) (
	input  logic clk,
	input  logic arst_n,
	cbsu_in_if   page,
	cbsu_out_if  result,
	cbsu_cfg_if  cfg,
	output int   fail_count,
	output int   awaited_count
);
	import cbsu_pkg::*;

	typedef struct packed {
		logic [6:0] character;
		logic [1:0] status;
		logic       last;
	} page_result_t;

	logic [15:0] accept_first;
	logic [15:0] accept_second;
	logic [7:0]  byte_pos;
	logic [2:0]  septet_phase;
	logic [6:0]  carry_bits;
	logic [7:0]  id_high;
	logic        id_match;
	logic        text_done;

	page_result_t awaited_results[$];

	task automatic clear_page_state();
		byte_pos     = '0;
		septet_phase = '0;
		carry_bits   = '0;
		id_high      = '0;
		id_match     = 1'b0;
		text_done    = 1'b0;
	endtask

	task automatic unpack_byte(input logic [7:0] b, input logic eom);
		logic [7:0]   pos;
		logic [2:0]   phase;
		logic [6:0]   septet;
		logic [15:0]  id;
		logic [15:0]  shifted;
		page_result_t fresh[$];

		pos = byte_pos;
		if (int'(pos) < MAX_PAGE_BYTES) begin
			if (pos == 8'd2) begin
				id_high = b;
			end else if (pos == 8'd3) begin
				id       = {id_high, b};
				id_match = (id == accept_first) || (id == accept_second);
			end
			if (int'(pos) >= HEADER_BYTES && id_match && !text_done) begin
				phase = septet_phase;
				if (phase > LAST_PHASE)
					phase = 3'd0;
				shifted    = 16'(b) << phase;
				septet     = shifted[6:0] | carry_bits;
				carry_bits = 7'(16'(b) >> (SEPTET_BITS - phase));
				if (septet == CR_SEPTET) begin
					text_done = 1'b1;
				end else begin
					fresh.push_back('{septet, STATUS_CHAR, 1'b0});
					phase = (phase == LAST_PHASE) ? 3'd0 : phase + 3'd1;
					if (phase == 3'd0) begin
						fresh.push_back('{carry_bits, STATUS_CHAR, 1'b0});
						carry_bits = '0;
					end
					septet_phase = phase;
				end
			end
		end

		if (byte_pos < POS_LIMIT)
			byte_pos = byte_pos + 8'd1;

		if (eom) begin
			fresh.push_back('{7'd0,
				(id_match && (int'(pos) + 1 >= HEADER_BYTES)) ? STATUS_OK : STATUS_ERR, 1'b0});
			clear_page_state();
		end

		if (fresh.size() > 0)
			fresh[fresh.size() - 1].last = 1'b1;
		foreach (fresh[i])
			awaited_results.push_back(fresh[i]);
	endtask

	task automatic check_result();
		page_result_t want;

		if (awaited_results.size() == 0) begin
			$error("unexpected result: character %0h status %0d last %0b",
				result.character, result.status, result.last);
			fail_count++;
		end else begin
			want = awaited_results.pop_front();
			if (result.character !== want.character) begin
				$error("character: expected %0h, actual %0h", want.character, result.character);
				fail_count++;
			end
			if (result.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, result.status);
				fail_count++;
			end
			if (result.last !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, result.last);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_first  = ACCEPT_FIRST_RESET;
			accept_second = ACCEPT_SECOND_RESET;
			clear_page_state();
			awaited_results.delete();
			fail_count    = 0;
			awaited_count = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_ACCEPT_FIRST)
					accept_first = cfg.data;
				else
					accept_second = cfg.data;
			end
			if (page.valid && page.ready)
				unpack_byte(page.data_byte, page.end_of_message);
			if (result.valid && result.ready)
				check_result();
			awaited_count = awaited_results.size();
		end
	end

endmodule

FILE: tb/cell_broadcast_septet_unpacker_top_tb.sv
`timescale 1ns / 1ps

module cell_broadcast_septet_unpacker_top_tb;
	import cbsu_pkg::*;

	localparam int HEADER_BYTES   = 6;
	localparam int MAX_PAGE_BYTES = 255;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int HOLD_CYCLES    = 200;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASE_BYTES    = 36;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	cbsu_in_if  page ();
	cbsu_out_if result ();
	cbsu_cfg_if cfg ();

	int fail_count;
	int awaited_count;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int bytes_sent     = 0;
	int cycle_count;
	bit hold_armed     = 1'b0;
	bit hold_done      = 1'b0;

	logic [15:0] cur_first  = ACCEPT_FIRST_RESET;
	logic [15:0] cur_second = ACCEPT_SECOND_RESET;
	logic [7:0]  page_bytes[$];

	cell_broadcast_septet_unpacker_top #(
		.HEADER_BYTES   (HEADER_BYTES),
		.MAX_PAGE_BYTES (MAX_PAGE_BYTES)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.page   (page),
		.result (result),
		.cfg    (cfg)
	);

	cbsu_page_checker #(
		.HEADER_BYTES   (HEADER_BYTES),
		.MAX_PAGE_BYTES (MAX_PAGE_BYTES)
	) page_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.page          (page),
		.result        (result),
		.cfg           (cfg),
		.fail_count    (fail_count),
		.awaited_count (awaited_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("cell_broadcast_septet_unpacker_top regression: fail");
		$finish;
	end

	// The long hold lets the job queue fill so that the page input stalls.
	initial begin
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_armed && !hold_done) begin
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				result.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eom);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			page.valid <= 1'b0;
			@(negedge clk);
		end
		page.valid          <= 1'b1;
		page.data_byte      <= b;
		page.end_of_message <= eom;
		do @(posedge clk); while (!page.ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_page();
		foreach (page_bytes[i])
			send_byte(page_bytes[i], i == page_bytes.size() - 1);
		page_bytes.delete();
	endtask

	task automatic add_header(input logic [15:0] id);
		page_bytes.push_back(8'($urandom_range(0, 255)));
		page_bytes.push_back(8'($urandom_range(0, 255)));
		page_bytes.push_back(id[15:8]);
		page_bytes.push_back(id[7:0]);
		page_bytes.push_back(8'($urandom_range(0, 255)));
		page_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_raw(input int n);
		repeat (n) page_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_text(input int n, input int cr_at);
		logic [15:0] acc;
		logic [6:0]  septet;
		int          nbits;

		acc   = '0;
		nbits = 0;
		for (int i = 0; i < n; i++) begin
			if (i == cr_at) begin
				septet = CR_SEPTET;
			end else begin
				septet = 7'($urandom_range(0, 127));
				if (septet == CR_SEPTET)
					septet = 7'h20;
			end
			acc   = acc | (16'(septet) << nbits);
			nbits = nbits + 7;
			if (nbits >= 8) begin
				page_bytes.push_back(acc[7:0]);
				acc   = acc >> 8;
				nbits = nbits - 8;
			end
		end
		if (nbits > 0)
			page_bytes.push_back(acc[7:0]);
	endtask

	function automatic logic [15:0] pick_good_id();
		return ($urandom_range(0, 1) == 0) ? cur_first : cur_second;
	endfunction

	task automatic random_page();
		int kind;
		int n;
		int cr_at;
		int len;

		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			add_header(pick_good_id());
			n     = $urandom_range(0, 24);
			cr_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n) : -1;
			add_text(n, cr_at);
			if ($urandom_range(0, 3) == 0)
				add_raw($urandom_range(1, 4));
		end else if (kind < 70) begin
			add_header(pick_good_id());
			add_raw($urandom_range(0, 16));
		end else if (kind < 80) begin
			add_header(pick_good_id());
			len = $urandom_range(1, HEADER_BYTES);
			while (page_bytes.size() > len)
				void'(page_bytes.pop_back());
		end else if (kind < 90) begin
			add_header(pick_good_id() ^ (16'd1 << $urandom_range(0, 15)));
			add_text($urandom_range(0, 10), -1);
		end else begin
			add_raw($urandom_range(1, 14));
		end
		send_page();
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		if (idx == REG_ACCEPT_FIRST)
			cur_first = value;
		else
			cur_second = value;
	endtask

	task automatic set_ids(input logic [15:0] first_id, input logic [15:0] second_id);
		write_reg(REG_ACCEPT_FIRST, first_id);
		write_reg(REG_ACCEPT_SECOND, second_id);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		page.valid <= 1'b0;
		while (awaited_count != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int start_count;

		page.valid          = 1'b0;
		page.data_byte      = '0;
		page.end_of_message = 1'b0;
		cfg.valid           = 1'b0;
		cfg.index           = REG_ACCEPT_FIRST;
		cfg.data            = '0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_byte(8'hFF, 1'b1);

		add_header(ACCEPT_FIRST_RESET);
		repeat (6) page_bytes.push_back(8'hFF);
		page_bytes.push_back({CR_SEPTET, 1'b0});
		send_page();

		add_header(ACCEPT_SECOND_RESET);
		page_bytes.push_back({1'b0, CR_SEPTET});
		page_bytes.push_back(8'h00);
		send_page();

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			case (phase)
				0: begin
					set_ids(16'h0000, 16'hFFFF);
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					set_ids(16'hFFFF, 16'h0000);
					send_idle_pct  = 47;
					recv_stall_pct = 0;
				end
				2: begin
					set_ids(16'($urandom), 16'($urandom));
					send_idle_pct  = 0;
					recv_stall_pct = 47;
					hold_armed     = 1'b1;
				end
				default: begin
					set_ids(ACCEPT_FIRST_RESET, 16'($urandom));
					send_idle_pct  = 33;
					recv_stall_pct = 33;
				end
			endcase
			start_count = bytes_sent;
			while (bytes_sent - start_count < PHASE_BYTES)
				random_page();
			if (phase == 2) begin
				add_header(pick_good_id());
				add_text(300, -1);
				send_page();
			end
		end
		drain();

		if (fail_count == 0)
			$display("cell_broadcast_septet_unpacker_top regression: pass");
		else
			$display("cell_broadcast_septet_unpacker_top regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/cbsu_pkg.sv
rtl/core/cbsu_if.sv
rtl/core/cbsu_front.sv
rtl/core/cbsu_queue.sv
rtl/core/cbsu_back.sv
rtl/core/cell_broadcast_septet_unpacker_top.sv
tb/cbsu_page_checker.sv
tb/cell_broadcast_septet_unpacker_top_tb.sv
